### design/sbpe_pkg.sv
// ----------------------------------------------------------------------------
// Servo bus packet engine package
// Shared beat types, phase type, codes and constants.
// ----------------------------------------------------------------------------
package sbpe_pkg;

  localparam logic [1:0] OP_TX   = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_HDR_TMO    = 2'd1;
  localparam logic [1:0] ST_REPLY_TMO  = 2'd2;

  localparam logic [7:0]  HDR_BYTE      = 8'hFF;
  localparam logic [7:0]  BCAST_ID      = 8'hFE;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SEND   = 2'd1,
    PH_HEADER = 2'd2,
    PH_REPLY  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_in;
    logic       final_byte;
    logic [7:0] reply_count;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic [1:0] status;
    logic       receive_dir;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0]     cnt;
    out_t [2:0]     res;
  } burst_t;

  function automatic out_t mk_res(logic [1:0] kind, logic [7:0] b, logic [1:0] st,
                                  logic dir);
    out_t r;
    r.kind        = kind;
    r.byte_out    = b;
    r.status      = st;
    r.receive_dir = dir;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

### design/sbpe_in_reg.sv
// ----------------------------------------------------------------------------
// Servo bus packet engine input register
// Holds one input beat until the step unit takes it.
// ----------------------------------------------------------------------------
module sbpe_in_reg
  import sbpe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  input  logic fire,
  output logic item_valid,
  output in_t  item
);

  logic valid_r, valid_nxt;
  in_t  data_r;
  logic load;

  assign in_stall   = valid_r && !fire;
  assign load       = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

endmodule

### design/sbpe_step.sv
// ----------------------------------------------------------------------------
// Servo bus packet engine step unit
// Holds the transaction state and turns one item into up to three results.
// ----------------------------------------------------------------------------
module sbpe_step
  import sbpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        fire,
  input  in_t         item,
  output burst_t      burst
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        bcast_r, bcast_nxt;
  logic [1:0]  hseen_r, hseen_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        line_rx_r, line_rx_nxt;
  logic [15:0] timeout_r;

  logic [7:0]  sum_add;
  logic [1:0]  hseen_inc;
  logic [7:0]  left_dec;
  logic [1:0]  nres;
  out_t [2:0]  res;

  assign sum_add   = sum_r + item.byte_in;
  assign hseen_inc = hseen_r + 2'd1;
  assign left_dec  = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;

  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    bcast_nxt   = bcast_r;
    hseen_nxt   = hseen_r;
    left_nxt    = left_r;
    tick_nxt    = tick_r;
    line_rx_nxt = line_rx_r;
    nres        = 2'd0;
    res         = '0;
    unique case (item.op)
      OP_TX: begin
        if (phase_r == PH_IDLE) begin
          line_rx_nxt = 1'b0;
          res[0]      = mk_res(KIND_TX, HDR_BYTE, ST_OK, 1'b0);
          res[1]      = mk_res(KIND_TX, HDR_BYTE, ST_OK, 1'b0);
          res[2]      = mk_res(KIND_TX, item.byte_in, ST_OK, 1'b0);
          nres        = 2'd3;
          sum_nxt     = item.byte_in;
          bcast_nxt   = (item.byte_in == BCAST_ID);
          phase_nxt   = PH_SEND;
        end else if (phase_r == PH_SEND) begin
          res[0]  = mk_res(KIND_TX, item.byte_in, ST_OK, line_rx_r);
          nres    = 2'd1;
          sum_nxt = sum_add;
          if (item.final_byte) begin
            line_rx_nxt = 1'b1;
            res[1]      = mk_res(KIND_TX, ~sum_add, ST_OK, 1'b1);
            nres        = 2'd2;
            if (bcast_r) begin
              res[2]    = mk_res(KIND_STATUS, 8'd0, ST_OK, 1'b1);
              nres      = 2'd3;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_HEADER;
              hseen_nxt = 2'd0;
              tick_nxt  = 16'd0;
              left_nxt  = item.reply_count;
            end
          end
        end
      end
      OP_RX: begin
        if (phase_r == PH_HEADER) begin
          if (item.byte_in == HDR_BYTE) begin
            hseen_nxt = hseen_inc;
            if (hseen_inc[1]) begin
              phase_nxt = PH_REPLY;
              tick_nxt  = 16'd0;
              if (left_r == 8'd0) begin
                res[0]    = mk_res(KIND_STATUS, 8'd0, ST_OK, line_rx_r);
                nres      = 2'd1;
                phase_nxt = PH_IDLE;
              end
            end
          end
        end else if (phase_r == PH_REPLY) begin
          res[0]   = mk_res(KIND_RX, item.byte_in, ST_OK, line_rx_r);
          nres     = 2'd1;
          left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            res[1]    = mk_res(KIND_STATUS, 8'd0, ST_OK, line_rx_r);
            nres      = 2'd2;
            phase_nxt = PH_IDLE;
          end
        end
      end
      OP_TICK: begin
        if (phase_r == PH_HEADER || phase_r == PH_REPLY) begin
          if (tick_r >= timeout_r) begin
            res[0]    = mk_res(KIND_STATUS, 8'd0,
                               (phase_r == PH_HEADER) ? ST_HDR_TMO : ST_REPLY_TMO,
                               line_rx_r);
            nres      = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            tick_nxt = tick_r + 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
    case (nres)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: begin
      end
    endcase
  end

  assign burst.cnt = nres;
  assign burst.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      sum_r     <= 8'd0;
      bcast_r   <= 1'b0;
      hseen_r   <= 2'd0;
      left_r    <= 8'd0;
      tick_r    <= 16'd0;
      line_rx_r <= 1'b1;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      sum_r     <= sum_nxt;
      bcast_r   <= bcast_nxt;
      hseen_r   <= hseen_nxt;
      left_r    <= left_nxt;
      tick_r    <= tick_nxt;
      line_rx_r <= line_rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

endmodule

### design/sbpe_out_ser.sv
// ----------------------------------------------------------------------------
// Servo bus packet engine output serializer
// Holds the results of one item and sends them one beat at a time.
// ----------------------------------------------------------------------------
module sbpe_out_ser
  import sbpe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   free,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  out_t [2:0] slot_r;
  logic       take;

  assign out_valid = (cnt_r != 2'd0);
  assign take      = out_valid && !out_stall;
  assign free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && take);
  assign out_data  = slot_r[0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = burst.cnt;
    end else if (take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= burst.res;
    end else if (take) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule

### design/servo_bus_packet_engine.sv
// ----------------------------------------------------------------------------
// Servo bus packet engine
// Frames outgoing servo packets and collects the reply on a half-duplex bus.
// ----------------------------------------------------------------------------
// The input channel carries one beat per event: a packet byte to send, a byte
// received from the bus, or a timer tick. The output channel carries bytes to
// transmit, reply bytes received and one status beat per transaction, with
// last set on the final beat caused by each input beat. The cfg port sets the
// per-phase tick limit.
// An accepted beat is registered and processed once the serializer is free.
// Its first result is valid in the cycle after that processing cycle. An
// input beat is taken every cycle while each causes at most one result and
// the output is not stalled; a beat with several results holds the output
// until all are taken, so a first byte or a final byte holds back the next.
// The three-entry output serializer sets that rate.
// Reset returns the engine to idle with the line in receive direction and
// the tick limit at 50. A stall on the output holds the current beat; once
// the serializer and input register are full, in_stall rises.
// ----------------------------------------------------------------------------
module servo_bus_packet_engine
  import sbpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic   item_valid;
  in_t    item;
  logic   ser_free;
  logic   fire;
  burst_t burst;

  assign fire = item_valid && ser_free;

  sbpe_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  sbpe_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .burst     (burst)
  );

  sbpe_out_ser u_out_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .burst     (burst),
    .free      (ser_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A processed item with results shows its first beat in the next cycle.
  a_burst_shown: assert property (@(posedge clk) disable iff (!rst_n)
    fire && burst.cnt != 2'd0 |=> out_valid)
    else $error("results of a processed item were not presented");

  // Status beats carry no byte and always leave the line receiving.
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STATUS |->
      out_data.byte_out == 8'd0 && out_data.receive_dir)
    else $error("malformed status beat");

  // An accepted input beat is held in the input register next cycle.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> item_valid)
    else $error("accepted input beat was lost");

  // A status beat always ends the results of its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STATUS |-> out_data.last)
    else $error("status beat not marked last");

endmodule
